// ----- hw/rtl/oft_pkg.sv -----
`default_nettype none
package oft_pkg;

  localparam int unsigned MaxChildrenDef = 16;
  localparam int unsigned IdW   = 32;
  localparam int unsigned LotW  = 31;
  localparam int unsigned AvgW  = 32;
  localparam int unsigned CostW = 63;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        child_id;
    logic [30:0]        quantity;
    logic signed [31:0] fill_qty;
    logic signed [31:0] reported_remaining;
    logic signed [31:0] fill_price;
  } in_word_t;

  typedef struct packed {
    logic        matched;
    logic [30:0] child_filled;
    logic [30:0] child_remaining;
    logic [31:0] child_avg_price;
    logic [62:0] child_cost;
    logic        some_fill;
    logic        plan_complete;
    logic        some_partial;
    logic [62:0] plan_cost;
    logic [62:0] global_filled;
    logic [30:0] last_price;
  } out_word_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [31:0] id;
    logic [30:0] req;
    logic [30:0] filled;
    logic [30:0] rem;
    logic [62:0] cost;
    logic [31:0] avg;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic        start;
    logic [62:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/order_fill_tracker_table.sv -----
// Order fill tracker table.
// Input channel in_valid/in_stall/in_word carries one command word: begin plan,
// add child, execution report or query child. Every command yields exactly one
// result word on out_valid/out_stall/out_word.
// The child table lives in one synchronous RAM of MaxChildren entries. A
// query or report first searches the table, one entry at a time, for the
// first entry with a matching id, then (for a report hit) updates the entry,
// running a 63-step serial divider for the average price on a priced fill,
// writes it back; every command then rescans all entries to build the plan
// flags and plan cost.
// One command is in work at a time; the next is accepted once the result is in
// the output register, even while it still waits to be taken.
// Reset clears the entry count, the global filled total and the last price;
// the table contents need no clearing. While out_stall is high the result
// word holds and at most one further command is worked off behind it.
`default_nettype none
module order_fill_tracker_table
  import oft_pkg::*;
#(
  parameter int unsigned MaxChildren = MaxChildrenDef
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int unsigned AW = (MaxChildren > 1) ? $clog2(MaxChildren) : 1;
  localparam int unsigned CW = $clog2(MaxChildren + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxChildren);
  localparam logic [62:0] Max63 = {63{1'b1}};

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SRCH   = 9'b000000010,
    S_SCHK   = 9'b000000100,
    S_UPD    = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_WB     = 9'b000100000,
    S_SCAN   = 9'b001000000,
    S_SACC   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e      st_r, st_nxt;
  in_word_t    cmd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [62:0] tot_r, tot_nxt;
  logic [30:0] lp_r, lp_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic        hit_r, hit_nxt;
  logic [AW-1:0] hidx_r, hidx_nxt;
  entry_t      ent_r, ent_nxt;
  logic        anyf_r, anyf_nxt, allf_r, allf_nxt, anyp_r, anyp_nxt;
  logic [62:0] pc_r, pc_nxt;
  logic [61:0] prod_r, prod_nxt;
  logic        ov_r, ov_nxt;
  out_word_t   ow_r, ow_nxt;
  logic        ov_valid_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [EntryW-1:0] rraw;
  div_req_t      dreq;
  div_rsp_t      drsp;

  oft_ram #(.Width(EntryW), .Depth(MaxChildren), .AddrW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rraw)
  );
  assign rdata = entry_t'(rraw);

  oft_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [31:0] fill;
  logic [31:0] fsum;
  logic [30:0] fnew, remv, cap;
  logic [63:0] csum;

  assign fill = cmd_r.fill_qty[31] ? '0 : cmd_r.fill_qty;
  assign in_stall = (st_r != S_IDLE);

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    tot_nxt  = tot_r;
    lp_nxt   = lp_r;
    ptr_nxt  = ptr_r;
    hit_nxt  = hit_r;
    hidx_nxt = hidx_r;
    ent_nxt  = ent_r;
    anyf_nxt = anyf_r;
    allf_nxt = allf_r;
    anyp_nxt = anyp_r;
    pc_nxt   = pc_r;
    prod_nxt = prod_r;
    ow_nxt   = ow_r;
    ov_valid_nxt = ov_r && out_stall;
    we       = 1'b0;
    waddr    = hidx_r;
    wdata    = ent_r;
    raddr    = ptr_r[AW-1:0];
    dreq     = '0;
    fsum     = {1'b0, ent_r.filled} + fill;
    fnew     = (fsum > {1'b0, ent_r.req}) ? ent_r.req : fsum[30:0];
    remv     = ent_r.req - fnew;
    cap      = cmd_r.reported_remaining[31] ? '0
             : (cmd_r.reported_remaining[30:0] | {31{1'b0}});
    if ((cmd_r.reported_remaining[31:0] != '0 && !cmd_r.reported_remaining[31])
        || fnew >= ent_r.req) begin
      if (cmd_r.reported_remaining[31] || cap < remv) begin
        remv = cmd_r.reported_remaining[31] ? '0 : cap;
      end
    end
    csum = {1'b0, ent_r.cost} + {2'b0, prod_r};
    unique case (st_r)
      S_IDLE: begin
        ptr_nxt = '0;
        hit_nxt = 1'b0;
        if (in_valid && !in_stall) begin
          unique case (cmd_e'(in_word.command))
            CMD_BEGIN: begin
              cnt_nxt = '0;
              tot_nxt = '0;
              lp_nxt  = '0;
              st_nxt  = S_SCAN;
            end
            CMD_ADD: begin
              if (cnt_r < MaxCnt) begin
                we       = 1'b1;
                waddr    = cnt_r[AW-1:0];
                wdata    = '{id: in_word.child_id, req: in_word.quantity,
                             filled: '0, rem: in_word.quantity, cost: '0, avg: '0};
                hit_nxt  = 1'b1;
                hidx_nxt = cnt_r[AW-1:0];
                cnt_nxt  = cnt_r + 1'b1;
              end
              st_nxt = S_SCAN;
            end
            CMD_REPORT: begin
              tot_nxt = ({1'b0, tot_r} + 64'(in_word.fill_qty[31] ? 32'd0
                        : in_word.fill_qty)) > {1'b0, Max63} ? Max63
                        : tot_r + 63'(in_word.fill_qty[31] ? 32'd0
                        : in_word.fill_qty);
              if (!in_word.fill_price[31] && in_word.fill_price != '0) begin
                lp_nxt = in_word.fill_price[30:0];
              end
              st_nxt = S_SRCH;
            end
            CMD_QUERY: st_nxt = S_SRCH;
            default:   st_nxt = S_SCAN;
          endcase
        end
      end
      S_SRCH: begin
        if (ptr_r >= cnt_r) begin
          ptr_nxt = '0;
          st_nxt  = S_SCAN;
        end else begin
          st_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rdata.id == cmd_r.child_id) begin
          hit_nxt  = 1'b1;
          hidx_nxt = ptr_r[AW-1:0];
          ent_nxt  = rdata;
          ptr_nxt  = '0;
          prod_nxt = 62'(fill[30:0]) * 62'(cmd_r.fill_price[30:0]);
          st_nxt   = (cmd_e'(cmd_r.command) == CMD_REPORT) ? S_UPD : S_SCAN;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          st_nxt  = S_SRCH;
        end
      end
      S_UPD: begin
        ent_nxt.filled = fnew;
        ent_nxt.rem    = remv;
        st_nxt = S_WB;
        if (fill != '0 && !cmd_r.fill_price[31] && cmd_r.fill_price != '0) begin
          ent_nxt.cost = csum[63] || csum[62:0] == Max63 ? Max63 : csum[62:0];
          if (csum[63]) ent_nxt.cost = Max63;
          if (fnew != '0) begin
            dreq.start    = 1'b1;
            dreq.dividend = ent_nxt.cost;
            dreq.divisor  = fnew;
            st_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          ent_nxt.avg = drsp.quotient;
          st_nxt = S_WB;
        end
      end
      S_WB: begin
        we     = 1'b1;
        ptr_nxt = '0;
        st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (ptr_r == '0) begin
          anyf_nxt = 1'b0;
          anyp_nxt = 1'b0;
          allf_nxt = (cnt_r != '0);
          pc_nxt   = '0;
        end
        if (ptr_r >= cnt_r) begin
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_SACC;
        end
      end
      S_SACC: begin
        if (rdata.filled != '0) anyf_nxt = 1'b1;
        if (!(rdata.req != '0 && rdata.filled >= rdata.req)) allf_nxt = 1'b0;
        if (rdata.filled != '0 && rdata.filled < rdata.req) anyp_nxt = 1'b1;
        pc_nxt = ({1'b0, pc_r} + {1'b0, rdata.cost}) > {1'b0, Max63} ? Max63
               : pc_r + rdata.cost;
        if (hit_r && ptr_r[AW-1:0] == hidx_r) ent_nxt = rdata;
        ptr_nxt = ptr_r + 1'b1;
        st_nxt  = S_SCAN;
      end
      S_OUT: begin
        if (!(ov_r && out_stall)) begin
          ow_nxt.matched         = hit_r;
          ow_nxt.child_filled    = hit_r ? ent_r.filled : '0;
          ow_nxt.child_remaining = hit_r ? ent_r.rem : '0;
          ow_nxt.child_avg_price = hit_r ? ent_r.avg : '0;
          ow_nxt.child_cost      = hit_r ? ent_r.cost : '0;
          ow_nxt.some_fill       = anyf_r;
          ow_nxt.plan_complete   = allf_r;
          ow_nxt.some_partial    = anyp_r;
          ow_nxt.plan_cost       = pc_r;
          ow_nxt.global_filled   = tot_r;
          ow_nxt.last_price      = lp_r;
          ov_valid_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      tot_r <= '0;
      lp_r  <= '0;
      ov_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      tot_r <= tot_nxt;
      lp_r  <= lp_nxt;
      ov_r  <= ov_valid_nxt;
      hit_r <= hit_nxt;
    end
    if (in_valid && !in_stall) begin
      cmd_r <= in_word;
    end
    ptr_r  <= ptr_nxt;
    hidx_r <= hidx_nxt;
    ent_r  <= ent_nxt;
    anyf_r <= anyf_nxt;
    allf_r <= allf_nxt;
    anyp_r <= anyp_nxt;
    pc_r   <= pc_nxt;
    prod_r <= prod_nxt;
    ow_r   <= ow_nxt;
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MaxCnt)
    else $error("entry count above table size");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ow_r)))
    else $error("stalled result word changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV) |-> (drsp.busy || drsp.done))
    else $error("waiting on idle divider");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (st_r == S_IDLE))
    else $error("command accepted while busy");

endmodule
`default_nettype wire

// ----- hw/rtl/oft_ram.sv -----
`default_nettype none
module oft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/oft_div.sv -----
`default_nettype none
module oft_div
  import oft_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  // Restoring division, one quotient bit per cycle, saturated to 32 bits.
  logic [62:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[30:0], quo_r[62]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd62;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[61:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[61:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = (quo_r[62:32] != '0) ? 32'hFFFF_FFFF : quo_r[31:0];

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("divider done without work");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import oft_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [62:0] Max63 = {63{1'b1}};
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam int unsigned CycleLimit = 2_000_000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;

  order_fill_tracker_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  logic [31:0] tbl_id [Depth];
  logic [30:0] tbl_req [Depth];
  logic [30:0] tbl_fill [Depth];
  logic [30:0] tbl_rem [Depth];
  logic [62:0] tbl_cost [Depth];
  logic [31:0] tbl_avg [Depth];
  int unsigned tbl_count;
  logic [62:0] sum_filled;
  logic [30:0] recent_price;

  out_word_t fill_results[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned hold_off;
  bit quiet_out;
  logic [31:0] known_ids[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [62:0] add_sat(logic [62:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > {2'b0, Max63}) ? Max63 : s[62:0];
  endfunction

  function automatic int lookup_child(logic [31:0] id);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic track_fill(input in_word_t w);
    out_word_t r;
    int idx;
    logic [63:0] fill;
    logic [63:0] f;
    logic [63:0] rem;
    logic [63:0] cap;
    logic [63:0] q;
    logic [62:0] pc;
    bit all;
    idx = -1;
    r = '0;
    pc = '0;
    case (cmd_e'(w.command))
      CMD_BEGIN: begin
        tbl_count = 0;
        sum_filled = '0;
        recent_price = '0;
      end
      CMD_ADD: begin
        if (tbl_count < Depth) begin
          idx = tbl_count;
          tbl_id[idx] = w.child_id;
          tbl_req[idx] = w.quantity;
          tbl_fill[idx] = '0;
          tbl_rem[idx] = w.quantity;
          tbl_cost[idx] = '0;
          tbl_avg[idx] = '0;
          tbl_count++;
        end
      end
      CMD_REPORT: begin
        fill = (w.fill_qty > 0) ? 64'(w.fill_qty) : 64'd0;
        sum_filled = add_sat(sum_filled, fill);
        if (w.fill_price > 0) recent_price = w.fill_price[30:0];
        idx = lookup_child(w.child_id);
        if (idx >= 0) begin
          f = 64'(tbl_fill[idx]) + fill;
          if (f > 64'(tbl_req[idx])) f = 64'(tbl_req[idx]);
          tbl_fill[idx] = f[30:0];
          rem = 64'(tbl_req[idx]) - f;
          if (w.reported_remaining > 0 || f >= 64'(tbl_req[idx])) begin
            cap = (w.reported_remaining > 0) ? 64'(w.reported_remaining) : 64'd0;
            if (cap < rem) rem = cap;
          end
          tbl_rem[idx] = rem[30:0];
          if (fill > 0 && w.fill_price > 0) begin
            tbl_cost[idx] = add_sat(tbl_cost[idx], fill * 64'(w.fill_price));
            if (f > 0) begin
              q = 64'(tbl_cost[idx]) / f;
              tbl_avg[idx] = (q > 64'(Max32)) ? Max32 : q[31:0];
            end
          end
        end
      end
      default: idx = lookup_child(w.child_id);
    endcase
    all = tbl_count > 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_fill[i] > 0) r.some_fill = 1'b1;
      if (!(tbl_req[i] > 0 && tbl_fill[i] >= tbl_req[i])) all = 1'b0;
      if (tbl_fill[i] > 0 && tbl_fill[i] < tbl_req[i]) r.some_partial = 1'b1;
      pc = add_sat(pc, 64'(tbl_cost[i]));
    end
    if (idx >= 0) begin
      r.matched = 1'b1;
      r.child_filled = tbl_fill[idx];
      r.child_remaining = tbl_rem[idx];
      r.child_avg_price = tbl_avg[idx];
      r.child_cost = tbl_cost[idx];
    end
    r.plan_complete = all;
    r.plan_cost = pc;
    r.global_filled = sum_filled;
    r.last_price = recent_price;
    fill_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (fill_results.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_word.matched), 64'd0);
      end else begin
        w = fill_results.pop_front();
        if (out_word.matched !== w.matched)
          report_mismatch("matched", 64'(out_word.matched), 64'(w.matched));
        if (out_word.child_filled !== w.child_filled)
          report_mismatch("child_filled", 64'(out_word.child_filled), 64'(w.child_filled));
        if (out_word.child_remaining !== w.child_remaining)
          report_mismatch("child_remaining", 64'(out_word.child_remaining),
                          64'(w.child_remaining));
        if (out_word.child_avg_price !== w.child_avg_price)
          report_mismatch("child_avg_price", 64'(out_word.child_avg_price),
                          64'(w.child_avg_price));
        if (out_word.child_cost !== w.child_cost)
          report_mismatch("child_cost", 64'(out_word.child_cost), 64'(w.child_cost));
        if (out_word.some_fill !== w.some_fill)
          report_mismatch("some_fill", 64'(out_word.some_fill), 64'(w.some_fill));
        if (out_word.plan_complete !== w.plan_complete)
          report_mismatch("plan_complete", 64'(out_word.plan_complete),
                          64'(w.plan_complete));
        if (out_word.some_partial !== w.some_partial)
          report_mismatch("some_partial", 64'(out_word.some_partial),
                          64'(w.some_partial));
        if (out_word.plan_cost !== w.plan_cost)
          report_mismatch("plan_cost", 64'(out_word.plan_cost), 64'(w.plan_cost));
        if (out_word.global_filled !== w.global_filled)
          report_mismatch("global_filled", 64'(out_word.global_filled),
                          64'(w.global_filled));
        if (out_word.last_price !== w.last_price)
          report_mismatch("last_price", 64'(out_word.last_price), 64'(w.last_price));
      end
    end
  end

  int unsigned burst_left;

  // Offers one word and holds it until accepted; gaps come between bursts.
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_fill(w);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  function automatic in_word_t make_word(cmd_e c, logic [31:0] id, logic [30:0] qty,
                                         logic [31:0] fl, logic [31:0] rr,
                                         logic [31:0] pr);
    in_word_t w;
    w.command = c;
    w.child_id = id;
    w.quantity = qty;
    w.fill_qty = fl;
    w.reported_remaining = rr;
    w.fill_price = pr;
    return w;
  endfunction

  function automatic logic [31:0] rand_signed();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return -$urandom_range(1, 100);
      4: return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_qty();
    case ($urandom_range(0, 4))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(1, 50));
      3: return 31'($urandom_range(1, 5000));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_word(make_word(CMD_QUERY, 32'd5, '0, '0, '0, '0));
    send_word(make_word(CMD_REPORT, 32'd5, '0, 32'd10, 32'd0, 32'd7));
    send_word(make_word(CMD_BEGIN, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1, '1, '1));
    send_word(make_word(CMD_ADD, 32'd0, 31'd100, '0, '0, '0));
    send_word(make_word(CMD_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '0, '0, '0));
    send_word(make_word(CMD_ADD, 32'd0, 31'd5, '0, '0, '0));
    send_word(make_word(CMD_ADD, 32'd9, 31'd0, '0, '0, '0));
    send_word(make_word(CMD_REPORT, 32'd0, '0, 32'd40, 32'd60, 32'd3));
    send_word(make_word(CMD_REPORT, 32'd0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_word(make_word(CMD_REPORT, 32'd0, '0, 32'd500, 32'd7, 32'd2));
    send_word(make_word(CMD_REPORT, 32'hFFFF_FFFF, '0, 32'h7FFF_FFFF, 32'd0,
                        32'h7FFF_FFFF));
    repeat (6) send_word(make_word(CMD_REPORT, 32'hFFFF_FFFF, '0, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(make_word(CMD_REPORT, 32'd9, '0, 32'd4, 32'd4, 32'd4));
    send_word(make_word(CMD_QUERY, 32'd0, '0, '0, '0, '0));
    send_word(make_word(CMD_QUERY, 32'd77, '0, '0, '0, '0));
    for (int i = 0; i < 14; i++)
      send_word(make_word(CMD_ADD, 32'd100 + i, 31'd1, '0, '0, '0));
  endtask

  task automatic test_random_plans();
    logic [31:0] id;
    int n;
    n = 0;
    while (n < 1250) begin
      send_word(make_word(CMD_BEGIN, $urandom, rand_qty(), $urandom, $urandom, $urandom));
      n++;
      known_ids.delete();
      repeat ($urandom_range(1, 17)) begin
        id = ($urandom_range(0, 3) == 0 && known_ids.size() > 0)
             ? known_ids[$urandom_range(0, known_ids.size() - 1)]
             : (($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) : $urandom);
        known_ids.push_back(id);
        send_word(make_word(CMD_ADD, id, rand_qty(), $urandom, $urandom, $urandom));
        n++;
      end
      repeat ($urandom_range(5, 40)) begin
        id = ($urandom_range(0, 5) != 0)
             ? known_ids[$urandom_range(0, known_ids.size() - 1)] : $urandom;
        send_word(make_word(($urandom_range(0, 4) == 0) ? CMD_QUERY : CMD_REPORT, id,
                            31'($urandom), rand_signed(), rand_signed(), rand_signed()));
        n++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    burst_left = 30;
    for (int i = 0; i < 20; i++)
      send_word(make_word(($urandom_range(0, 1) == 0) ? CMD_QUERY : CMD_REPORT,
                          $urandom_range(0, 20), 31'($urandom), rand_signed(),
                          rand_signed(), rand_signed()));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    errors = 0;
    cycles = 0;
    hold_off = 0;
    quiet_out = 1'b0;
    burst_left = 0;
    tbl_count = 0;
    sum_filled = '0;
    recent_price = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_plans();
    in_valid <= 1'b0;
    quiet_out = 1'b1;
    while (fill_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
